@@ hdl/nrwrp_pkg.sv @@
// ---------------------------------------------------------------------------
// nrwrp_pkg
// Shared types and constants of the no-repeat window random picker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nrwrp_pkg;

    localparam int unsigned CFG_W     = 9;   // width of entry_count and window
    localparam int unsigned CFG_IDX_W = 2;   // register index width
    localparam int unsigned RAND_W    = 32;  // random word width
    localparam int unsigned OUT_W     = 8;   // chosen_index width
    localparam int unsigned TURN_W    = CFG_W;
    localparam int unsigned DIV_CNT_W = $clog2(RAND_W);

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] ENTRY_COUNT_RST = CFG_W'(256);
    localparam logic [CFG_W-1:0] WINDOW_RST      = CFG_W'(0);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_DIV,
        ST_PICK_RD,
        ST_PICK_GET,
        ST_SHIFT,
        ST_DONE
    } nrwrp_state_t;

endpackage

`default_nettype wire

@@ hdl/nrwrp_ram.sv @@
// ---------------------------------------------------------------------------
// nrwrp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrwrp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/no_repeat_window_random_picker.sv @@
// ---------------------------------------------------------------------------
// no_repeat_window_random_picker
// Picks one entry index per random word; in window mode recently picked
// indices are held out of the draw for a number of steps.
// ---------------------------------------------------------------------------
// Plain mode: accept, then the 32-step remainder unit, then the result.
// Window mode: countdown walk over n entries, 32-step remainder, pick read,
//   then a list shift over the entries above the pick (active_count counted
//   after the walk); no shift work when the pick is the last list entry.
// One item in flight; the next item is taken while a result waits.
// Reset and every write to entry_count or window start an init sweep over
//   all MAX_ENTRIES slots of both memories; no item is taken during the sweep.
`timescale 1ns / 1ps
`default_nettype none

module no_repeat_window_random_picker
    import nrwrp_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    // input items
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [RAND_W-1:0]    s_rand_word,
    // result items
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [OUT_W-1:0]     m_chosen_index
);

    localparam int unsigned IW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned XW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [XW-1:0] MAX_X   = XW'(MAX_ENTRIES);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_ENTRIES);
    localparam logic [IW-1:0] LAST_IX = IW'(MAX_ENTRIES - 1);

    nrwrp_state_t state_reg, state_next;

    logic [CFG_W-1:0]     entry_count_reg;
    logic [CFG_W-1:0]     window_reg;
    logic [IW-1:0]        init_k_reg;
    logic [CW-1:0]        count_reg;
    logic [RAND_W-1:0]    div_q_reg;
    logic [CW-1:0]        rem_reg;
    logic [CW-1:0]        divisor_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [CW-1:0]        walk_k_reg;
    logic                 walk_vld_reg;
    logic [IW-1:0]        walk_addr_reg;
    logic [CW-1:0]        sh_rd_reg;
    logic                 sh_vld_reg;
    logic [IW-1:0]        sh_wa_reg;
    logic [OUT_W-1:0]     result_reg;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;

    // effective count and window
    logic [XW-1:0]    ec_x;
    logic [XW-1:0]    n_x;
    logic [CW-1:0]    eff_n;
    logic [CFG_W-1:0] eff_w;
    logic             window_mode;
    logic             cfg_hit;

    // memory ports
    logic              list_we;
    logic [IW-1:0]     list_wa;
    logic [IW-1:0]     list_wd;
    logic [IW-1:0]     list_ra;
    logic [IW-1:0]     list_rd;
    logic              turns_we;
    logic [IW-1:0]     turns_wa;
    logic [TURN_W-1:0] turns_wd;
    logic [IW-1:0]     turns_ra;
    logic [TURN_W-1:0] turns_rd;

    // datapath helpers
    logic [CW:0]   trial;
    logic          trial_ge;
    logic [CW-1:0] rem_step;
    logic          div_last;
    logic          walk_issue;
    logic          walk_done;
    logic          walk_release;
    logic          sh_issue;
    logic          sh_done;
    logic          out_free;

    always_comb begin
        ec_x = XW'(entry_count_reg);
        if (ec_x == '0) begin
            n_x = XW'(1);
        end else if (ec_x > MAX_X) begin
            n_x = MAX_X;
        end else begin
            n_x = ec_x;
        end
        eff_n = CW'(n_x);
        eff_w = (XW'(window_reg) > n_x) ? CFG_W'(n_x) : window_reg;
        window_mode = (eff_w > CFG_W'(1));
    end

    assign cfg_hit = cfg_wr_en && (cfg_index == REG_ENTRY_COUNT || cfg_index == REG_WINDOW);

    // restoring remainder, one quotient bit per cycle
    assign trial    = {rem_reg, div_q_reg[RAND_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});
    assign rem_step = trial_ge ? CW'(trial - {1'b0, divisor_reg}) : CW'(trial);
    assign div_last = (div_cnt_reg == DIV_CNT_W'(RAND_W - 1));

    assign walk_issue   = (walk_k_reg < eff_n);
    assign walk_done    = !walk_issue && !walk_vld_reg;
    assign walk_release = walk_vld_reg && (turns_rd == TURN_W'(1)) && (count_reg != MAX_C);
    assign sh_issue     = (sh_rd_reg < count_reg);
    assign sh_done      = !sh_issue && !sh_vld_reg;
    assign out_free     = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (init_k_reg == LAST_IX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = window_mode ? ST_WALK : ST_DIV;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = window_mode ? ST_PICK_RD : ST_DONE;
                end
            end
            ST_PICK_RD:  state_next = ST_PICK_GET;
            ST_PICK_GET: state_next = ST_SHIFT;
            ST_SHIFT: begin
                if (sh_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
        if (cfg_hit) begin
            state_next = ST_INIT;
        end
    end

    // memory controls and handshake
    always_comb begin
        s_ready  = 1'b0;
        list_we  = 1'b0;
        list_wa  = '0;
        list_wd  = '0;
        list_ra  = '0;
        turns_we = 1'b0;
        turns_wa = '0;
        turns_wd = '0;
        turns_ra = '0;
        case (state_reg)
            ST_INIT: begin
                list_we  = 1'b1;
                list_wa  = init_k_reg;
                list_wd  = init_k_reg;
                turns_we = 1'b1;
                turns_wa = init_k_reg;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_WALK: begin
                turns_ra = IW'(walk_k_reg);
                // count down held-out entries; append the ones that expire
                turns_we = walk_vld_reg && (turns_rd != '0);
                turns_wa = walk_addr_reg;
                turns_wd = turns_rd - TURN_W'(1);
                list_we  = walk_release;
                list_wa  = IW'(count_reg);
                list_wd  = walk_addr_reg;
            end
            ST_PICK_RD: begin
                list_ra = IW'(rem_reg);
            end
            ST_PICK_GET: begin
                turns_we = 1'b1;
                turns_wa = list_rd;
                turns_wd = eff_w;
            end
            ST_SHIFT: begin
                list_ra = IW'(sh_rd_reg);
                list_we = sh_vld_reg;
                list_wa = sh_wa_reg;
                list_wd = list_rd;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // configuration registers and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_INIT;
            entry_count_reg <= ENTRY_COUNT_RST;
            window_reg      <= WINDOW_RST;
            init_k_reg      <= '0;
            count_reg       <= '0;
            walk_vld_reg    <= 1'b0;
            sh_vld_reg      <= 1'b0;
            div_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            // load a new result or drop the one just taken
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    if (!cfg_hit) begin
                        init_k_reg <= init_k_reg + IW'(1);
                    end
                    if (init_k_reg == LAST_IX) begin
                        count_reg <= eff_n;
                    end
                end
                ST_IDLE: begin
                    walk_vld_reg <= 1'b0;
                    div_cnt_reg  <= '0;
                end
                ST_WALK: begin
                    walk_vld_reg <= walk_issue;
                    if (walk_release) begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                end
                ST_PICK_GET: begin
                    sh_vld_reg <= 1'b0;
                end
                ST_SHIFT: begin
                    sh_vld_reg <= sh_issue;
                    if (sh_done) begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
                default: begin
                    walk_vld_reg <= 1'b0;
                end
            endcase
            if (cfg_wr_en) begin
                if (cfg_index == REG_ENTRY_COUNT) begin
                    entry_count_reg <= cfg_wr_data;
                end
                if (cfg_index == REG_WINDOW) begin
                    window_reg <= cfg_wr_data;
                end
            end
            if (cfg_hit) begin
                init_k_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                div_q_reg   <= s_rand_word;
                rem_reg     <= '0;
                divisor_reg <= eff_n;
                walk_k_reg  <= '0;
            end
            ST_WALK: begin
                if (walk_issue) begin
                    walk_k_reg <= walk_k_reg + CW'(1);
                end
                walk_addr_reg <= IW'(walk_k_reg);
                divisor_reg   <= count_reg;
                result_reg    <= '0;
            end
            ST_DIV: begin
                div_q_reg  <= {div_q_reg[RAND_W-2:0], 1'b0};
                rem_reg    <= rem_step;
                result_reg <= OUT_W'(rem_step);
            end
            ST_PICK_GET: begin
                result_reg <= OUT_W'(list_rd);
                sh_rd_reg  <= rem_reg + CW'(1);
            end
            ST_SHIFT: begin
                if (sh_issue) begin
                    sh_rd_reg <= sh_rd_reg + CW'(1);
                end
                // data read now lands one slot lower next cycle
                sh_wa_reg <= IW'(sh_rd_reg - CW'(1));
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg <= result_reg;
                end
            end
            default: begin
                walk_addr_reg <= walk_addr_reg;
            end
        endcase
    end

    nrwrp_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ENTRIES)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (list_we),
        .wr_addr (list_wa),
        .wr_data (list_wd),
        .rd_addr (list_ra),
        .rd_data (list_rd)
    );

    nrwrp_ram #(
        .WIDTH (TURN_W),
        .DEPTH (MAX_ENTRIES)
    ) u_turns_ram (
        .aclk    (aclk),
        .wr_en   (turns_we),
        .wr_addr (turns_wa),
        .wr_data (turns_wd),
        .rd_addr (turns_ra),
        .rd_data (turns_rd)
    );

    assign m_valid        = m_valid_reg;
    assign m_chosen_index = m_data_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_no_repeat_window_random_picker.sv @@
// ---------------------------------------------------------------------------
// tb_no_repeat_window_random_picker
// Drives random words into the picker, tracks the active list and the
// hold-out countdowns in a local predictor, and checks every chosen index
// in order. Covers plain mode, window mode, count and window saturation,
// writes to an unused register index, and random phases with random idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_no_repeat_window_random_picker;
    import nrwrp_pkg::*;

    localparam int unsigned MAX_ENTRIES   = 256;
    localparam int unsigned SETTLE_CYCLES = 600;   // idle wait after the last pick is back
    localparam int unsigned RANDOM_ITEMS  = 780;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [RAND_W-1:0]    s_rand_word;
    logic                 m_valid;
    logic                 m_ready;
    logic [OUT_W-1:0]     m_chosen_index;

    // predictor state
    logic [CFG_W-1:0] cfg_entries;
    logic [CFG_W-1:0] cfg_window;
    int unsigned      free_list [MAX_ENTRIES];
    int unsigned      free_count;
    int unsigned      cooldown [MAX_ENTRIES];
    bit               held [MAX_ENTRIES];

    logic [OUT_W-1:0] picks_due [$];
    int unsigned      mismatch_count;
    bit               idle_on;

    no_repeat_window_random_picker dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rand_word    (s_rand_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chosen_index (m_chosen_index)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned effective_entries();
        int unsigned n;
        n = cfg_entries;
        if (n < 1) n = 1;
        if (n > MAX_ENTRIES) n = MAX_ENTRIES;
        return n;
    endfunction

    function automatic int unsigned effective_window();
        int unsigned n;
        n = effective_entries();
        return (cfg_window > n) ? n : cfg_window;
    endfunction

    function automatic void reload_pool();
        int unsigned n;
        n = effective_entries();
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            free_list[k] = (k < n) ? k : 0;
            cooldown[k]  = 0;
            held[k]      = 1'b0;
        end
        free_count = n;
    endfunction

    function automatic logic [OUT_W-1:0] predict_pick(input logic [RAND_W-1:0] word);
        int unsigned n, w, pos, pick;
        n = effective_entries();
        w = effective_window();
        if (w <= 1) return OUT_W'(word % n);
        // release countdowns that run out, in ascending index order
        for (int k = 0; k < n; k++) begin
            if (held[k]) begin
                if (cooldown[k] != 0) cooldown[k]--;
                if (cooldown[k] == 0) begin
                    held[k] = 1'b0;
                    if (free_count < MAX_ENTRIES) begin
                        free_list[free_count] = k;
                        free_count++;
                    end
                end
            end
        end
        if (free_count == 0) return '0;
        pos  = word % free_count;
        pick = free_list[pos];
        for (int k = pos; k + 1 < free_count; k++)
            free_list[k] = free_list[k + 1];
        free_count--;
        cooldown[pick] = w;
        held[pick]     = 1'b1;
        return OUT_W'(pick);
    endfunction

    // result side: stall in random bursts while idling is on
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin : watch_results
        logic [OUT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (picks_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: chosen_index %0d", m_chosen_index);
            end else begin
                want = picks_due.pop_front();
                if (m_chosen_index !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("chosen_index mismatch: expected %0d, got %0d",
                                 want, m_chosen_index);
                end
            end
        end
    end

    task automatic send_word(input logic [RAND_W-1:0] word);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_rand_word = word;
        do @(posedge aclk); while (!s_ready);
        picks_due = {picks_due, predict_pick(word)};
    endtask

    // hold the sender until every pick is back and the block has settled
    task automatic drain_picks();
        @(negedge aclk);
        s_valid = 1'b0;
        while (picks_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_picks();
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == REG_ENTRY_COUNT) begin
            cfg_entries = val;
            reload_pool();
        end else if (idx == REG_WINDOW) begin
            cfg_window = val;
            reload_pool();
        end
    endtask

    task automatic test_reset_plain();
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        send_word(32'd511);
    endtask

    task automatic test_count_limits();
        write_reg(REG_ENTRY_COUNT, 9'd0);       // zero acts as one entry
        send_word(32'hFFFF_FFFF);
        send_word(32'h0001_2345);
        write_reg(REG_ENTRY_COUNT, 9'h1FF);     // clamps to MAX_ENTRIES
        send_word(32'hFFFF_FFFF);
        write_reg(REG_WINDOW, 9'd1);            // window of one stays plain
        send_word(32'h0000_01FF);
    endtask

    task automatic test_window_basic();
        write_reg(REG_ENTRY_COUNT, 9'd4);
        write_reg(REG_WINDOW, 9'd4);            // window equal to count
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h0000_0007);
        send_word(32'h0000_0003);
        send_word(32'h0000_0001);
        send_word(32'h8000_0000);
        write_reg(REG_ENTRY_COUNT, 9'd5);
        write_reg(REG_WINDOW, 9'h1FF);          // saturates to the count
        for (int i = 0; i < 5; i++) send_word($urandom());
    endtask

    task automatic test_spare_index();
        // unused index: the active list must survive the write
        write_reg(REG_SPARE, 9'h1FF);
        for (int i = 0; i < 3; i++) send_word($urandom());
    endtask

    task automatic test_random_windows(input int unsigned target);
        int unsigned sent, burst, n, w, raw, sel;
        logic [RAND_W-1:0] word;
        sent = 0;
        while (sent < target) begin
            sel = $urandom_range(0, 11);
            if (sent == 0 || sel == 0) raw = 256;
            else if (sel == 1) raw = $urandom_range(257, 511);
            else if (sel == 2) raw = 0;
            else raw = $urandom_range(1, 40);
            if (sent == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_ENTRY_COUNT, CFG_W'(raw));
            n = effective_entries();
            if (sent == 0) begin
                w = 256;
            end else begin
                case ($urandom_range(0, 5))
                    0:       w = $urandom_range(0, 1);
                    1:       w = n;
                    2:       w = $urandom_range(n, 511);
                    default: w = $urandom_range(2, (n > 2) ? n : 2);
                endcase
            end
            write_reg(REG_WINDOW, CFG_W'(w));
            burst = (n > 64) ? 20 : $urandom_range(20, 60);
            for (int i = 0; i < burst && sent < target; i++) begin
                if (target - sent <= 150) idle_on = 1'b0;
                if (i == burst / 2 && $urandom_range(0, 3) == 0) drain_picks();
                case ($urandom_range(0, 7))
                    0:       word = $urandom_range(0, 600);
                    1:       word = 32'hFFFF_FFFF - $urandom_range(0, 600);
                    default: word = $urandom();
                endcase
                send_word(word);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_ENTRY_COUNT;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_rand_word    = '0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        cfg_entries    = ENTRY_COUNT_RST;
        cfg_window     = WINDOW_RST;
        reload_pool();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_plain();
        test_count_limits();
        test_window_basic();
        test_spare_index();
        test_random_windows(RANDOM_ITEMS);
        drain_picks();

        if (mismatch_count == 0 && picks_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
